FILE: hw/rtl/dqe_pkg.sv
// shared types and codes for the double-ended queue
package dqe_pkg;

  // command codes carried with each input transaction
  typedef enum logic [3:0] {
    CMD_PUSH_FRONT  = 4'd0,
    CMD_PUSH_REAR   = 4'd1,
    CMD_READ_AT     = 4'd2,
    CMD_WRITE_AT    = 4'd3,
    CMD_READ_FRONT  = 4'd4,
    CMD_WRITE_FRONT = 4'd5,
    CMD_READ_BACK   = 4'd6,
    CMD_WRITE_BACK  = 4'd7,
    CMD_CLEAR       = 4'd8
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // storage access and status decided for one command
  typedef struct packed {
    logic    we;
    logic    re;
    status_e status;
  } access_t;

endpackage

FILE: hw/rtl/dqe_ram.sv
// generic single-port ram with registered read
module dqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port share one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dqe_ctrl.sv
// head pointer, element count and address decode of the queue
module dqe_ctrl import dqe_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [3:0]    cmd_i,
  input  logic [7:0]    index_i,
  output access_t       access_o,
  output logic [PW-1:0] addr_o,
  output logic [CW-1:0] size_o
);

  localparam int LW = (CW > 8) ? CW : 8;

  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] head_m1;
  logic          full;
  logic          in_range;
  logic          we, re;
  status_e       status;

  // ring position of a logical offset from the front
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] head,
                                             input logic [PW-1:0] offs);
    logic [PW:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign full     = (count_q == CW'(DEPTH));
  assign head_m1  = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
  assign in_range = (LW'(index_i) < LW'(count_q));

  // command decode
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    status  = ST_OK;
    addr_o  = head_q;
    case (cmd_e'(cmd_i))
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr_o  = head_m1;
          head_d  = head_m1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr_o  = ring_pos(head_q, PW'(count_q));
          count_d = count_q + CW'(1);
        end
      end
      CMD_READ_AT, CMD_WRITE_AT: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          addr_o = ring_pos(head_q, PW'(index_i));
          re     = (cmd_e'(cmd_i) == CMD_READ_AT);
          we     = (cmd_e'(cmd_i) == CMD_WRITE_AT);
        end
      end
      CMD_READ_FRONT, CMD_WRITE_FRONT: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          addr_o = head_q;
          re     = (cmd_e'(cmd_i) == CMD_READ_FRONT);
          we     = (cmd_e'(cmd_i) == CMD_WRITE_FRONT);
        end
      end
      CMD_READ_BACK, CMD_WRITE_BACK: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          addr_o = ring_pos(head_q, PW'(count_q - CW'(1)));
          re     = (cmd_e'(cmd_i) == CMD_READ_BACK);
          we     = (cmd_e'(cmd_i) == CMD_WRITE_BACK);
        end
      end
      CMD_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign access_o.we     = we & accept_i;
  assign access_o.re     = re & accept_i;
  assign access_o.status = status;
  assign size_o          = count_d;

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: hw/rtl/double_ended_queue_top.sv
// Double-ended queue held as a ring buffer in one single-port RAM.
// Commands pass the middle stage, then the output register; throughput is one
// command per cycle unless the output stalls. The single RAM port takes at most
// one access per command; its registered read sets the two-stage pipeline.
// Reset: asynchronous active low; clears head pointer, count and valid flags.
// The RAM contents are not cleared; no clearing pass is needed.
module double_ended_queue_top import dqe_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int DATA_WIDTH = 32,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IN_W = ((8 + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_WIDTH + 2 + CW + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // index [7:0], value [8 +: DATA_WIDTH], zero fill above
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // cmd [3:0]
  input  logic [3:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // read_value, status, size, is_empty from the lowest bit up, zero fill above
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  logic [7:0]            index;
  logic [DATA_WIDTH-1:0] value;
  logic                  accept;
  logic                  advance;
  access_t               access;
  logic [PW-1:0]         addr;
  logic [CW-1:0]         size_next;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_read_q;
  status_e               s1_status_q;
  logic [CW-1:0]         s1_size_q;

  logic                  m_valid_q, m_valid_d;
  logic [DATA_WIDTH-1:0] rd_q;
  status_e               status_q;
  logic [CW-1:0]         size_q;

  assign index = s_axis_tdata_i[7:0];
  assign value = s_axis_tdata_i[8 +: DATA_WIDTH];

  // handshake: the middle stage moves when the output register is free or drains
  assign advance         = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  dqe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (s_axis_tuser_i),
    .index_i  (index),
    .access_o (access),
    .addr_o   (addr),
    .size_o   (size_next)
  );

  dqe_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (access.we),
    .re_i    (access.re),
    .addr_i  (addr),
    .wdata_i (value),
    .rdata_o (rdata)
  );

  assign s1_valid_d = accept || (s1_valid_q && !advance);
  assign m_valid_d  = advance || (m_valid_q && !m_axis_tready_i);

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // middle stage payload, waiting for the ram read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q   <= access.re;
      s1_status_q <= access.status;
      s1_size_q   <= size_next;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q     <= s1_read_q ? rdata : '0;
      status_q <= s1_status_q;
      size_q   <= s1_size_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_W'({(size_q == '0), size_q, status_q, rd_q});

`ifndef SYNTHESIS
  // a command never both reads and writes the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(access.we && access.re))
    else $error("ram read and write in one transaction");

  // a pending read always belongs to a command that succeeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_read_q) |-> (s1_status_q == ST_OK))
    else $error("read issued for a failed command");

  // full is only reported while the store holds every entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (status_q == ST_FULL)) |-> (size_q == CW'(DEPTH)))
    else $error("full reported below capacity");

  // an accepted command occupies the middle stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction lost");
`endif

endmodule
